@@ rtl/pmfa_pkg.sv @@
// Shared constants, command codes and controller/datapath handshake types
// for the paged memory unit with frame allocator. No dependencies.
package pmfa_pkg;

  localparam int OFFSET_BITS  = 8;
  localparam int ADDRESS_BITS = 16;
  localparam int NUM_PROCS    = 8;

  localparam int PAGE_BITS  = ADDRESS_BITS - OFFSET_BITS;
  localparam int PAGE_COUNT = 2 ** PAGE_BITS;
  localparam int PAGE_BYTES = 2 ** OFFSET_BITS;
  localparam int SPACE_BYTES = 2 ** ADDRESS_BITS;
  localparam int PROC_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int MAP_BITS   = PROC_BITS + PAGE_BITS;
  localparam int LINK_W     = PAGE_BITS + 1;
  localparam int FREE_W     = PAGE_BITS + 1;
  localparam int CLR_W      = (ADDRESS_BITS > MAP_BITS) ? ADDRESS_BITS : MAP_BITS;

  // Fixed field widths of the channels.
  localparam int CMD_W   = 2;
  localparam int PID_W   = 4;
  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int DATA_W  = 8;
  localparam int BRK_W   = ADDRESS_BITS + 1;
  localparam int NPG_W   = SIZE_W + 1 - OFFSET_BITS;
  localparam int SUM_W   = ((SIZE_W + 1 > BRK_W) ? SIZE_W + 1 : BRK_W) + 1;

  localparam logic [LINK_W-1:0] LINK_END = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // Step commands from the controller.
  typedef struct packed {
    logic clear;
    logic in_ready;
    logic dec;
    logic look_chk;
    logic ram_done;
    logic scan_rd;
    logic scan_chk;
    logic scan_end;
    logic walk_rd;
    logic walk_chk;
    logic publish;
  } ctl_t;

  // Status flags back to the controller.
  typedef struct packed {
    logic clear_done;
    logic in_fire;
    logic pid_bad;
    logic is_alloc;
    logic alloc_ok;
    logic map_hit;
    logic is_read;
    logic is_write;
    logic scan_last;
    logic walk_stop_rd;
    logic walk_stop_chk;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/pmfa_if.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on pmfa_pkg for field widths.
interface pmfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [pmfa_pkg::CMD_W-1:0]    command;
  logic [pmfa_pkg::PID_W-1:0]    pid;
  logic [pmfa_pkg::ADDR_W-1:0]   address;
  logic [pmfa_pkg::SIZE_W-1:0]   alloc_size;
  logic [pmfa_pkg::DATA_W-1:0]   write_data;
  modport source (output valid, command, pid, address, alloc_size, write_data,
                  input ready);
  modport sink   (input valid, command, pid, address, alloc_size, write_data,
                  output ready);
endinterface

interface pmfa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [pmfa_pkg::ADDR_W-1:0]   alloc_address;
  logic [pmfa_pkg::DATA_W-1:0]   read_data;
  modport source (output valid, status, alloc_address, read_data, input ready);
  modport sink   (input valid, status, alloc_address, read_data, output ready);
endinterface

@@ rtl/pmfa_ctrl.sv @@
// Sequencing state machine of the paged memory unit.
// Depends on pmfa_pkg for the ctl_t and sts_t types.
module pmfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  pmfa_pkg::sts_t sts,
  output pmfa_pkg::ctl_t ctl
);
  import pmfa_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b000000000001,
    ST_IDLE     = 12'b000000000010,
    ST_DECODE   = 12'b000000000100,
    ST_LOOK_CHK = 12'b000000001000,
    ST_RAM      = 12'b000000010000,
    ST_SCAN_RD  = 12'b000000100000,
    ST_SCAN_CHK = 12'b000001000000,
    ST_SCAN_END = 12'b000010000000,
    ST_WALK_RD  = 12'b000100000000,
    ST_WALK_CHK = 12'b001000000000,
    ST_DONE     = 12'b010000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (sts.in_fire) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (sts.pid_bad) state_nxt = ST_DONE;
        else if (sts.is_alloc) state_nxt = sts.alloc_ok ? ST_SCAN_RD : ST_DONE;
        else state_nxt = ST_LOOK_CHK;
      end
      ST_LOOK_CHK: begin
        if (!sts.map_hit || sts.is_write) state_nxt = ST_DONE;
        else if (sts.is_read) state_nxt = ST_RAM;
        else state_nxt = ST_WALK_RD;
      end
      ST_RAM:      state_nxt = ST_DONE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = sts.scan_last ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: state_nxt = ST_DONE;
      ST_WALK_RD:  state_nxt = sts.walk_stop_rd ? ST_DONE : ST_WALK_CHK;
      ST_WALK_CHK: state_nxt = sts.walk_stop_chk ? ST_DONE : ST_WALK_RD;
      ST_DONE:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.clear    = (state_r == ST_CLEAR);
    ctl.in_ready = (state_r == ST_IDLE);
    ctl.dec      = (state_r == ST_DECODE);
    ctl.look_chk = (state_r == ST_LOOK_CHK);
    ctl.ram_done = (state_r == ST_RAM);
    ctl.scan_rd  = (state_r == ST_SCAN_RD);
    ctl.scan_chk = (state_r == ST_SCAN_CHK);
    ctl.scan_end = (state_r == ST_SCAN_END);
    ctl.walk_rd  = (state_r == ST_WALK_RD);
    ctl.walk_chk = (state_r == ST_WALK_CHK);
    ctl.publish  = (state_r == ST_DONE) && sts.out_free;
  end

endmodule

@@ rtl/pmfa_dp.sv @@
// Datapath: request registers, frame/link/map/byte memories, counters and
// the result register. Depends on pmfa_pkg and the channel interfaces.
module pmfa_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  pmfa_pkg::ctl_t ctl,
  output pmfa_pkg::sts_t sts,
  pmfa_in_if.sink        in_ch,
  pmfa_out_if.source     out_ch
);
  import pmfa_pkg::*;

  // Request registers.
  cmd_t              cmd_r;
  logic [PID_W-1:0]  pid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [DATA_W-1:0] wdata_r;

  // Allocator and walker state.
  logic [BRK_W-1:0]     brk_r [NUM_PROCS];
  logic [FREE_W-1:0]    free_cnt_r;
  logic [FREE_W-1:0]    npg_r;
  logic [FREE_W-1:0]    k_r;
  logic [PAGE_BITS-1:0] i_r;
  logic [LINK_W-1:0]    prev_r;
  logic [PAGE_BITS-1:0] vp_r;
  logic [LINK_W-1:0]    cur_r;
  logic [FREE_W-1:0]    steps_r;
  logic [CLR_W-1:0]     clr_r;

  // Result staging and output register.
  logic              res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [DATA_W-1:0] res_rdata_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_rdata_r;

  // Memories.
  logic [PID_W-1:0]  owner_mem [PAGE_COUNT];
  logic              owner_vld_r [PAGE_COUNT];
  logic [LINK_W-1:0] link_mem [PAGE_COUNT];
  logic [PAGE_BITS:0] pm_mem [2**MAP_BITS];
  logic [DATA_W-1:0] ram_mem [SPACE_BYTES];

  logic [PID_W-1:0]   owner_q;
  logic               owner_vq;
  logic [LINK_W-1:0]  link_q;
  logic [PAGE_BITS:0] pm_q;
  logic [DATA_W-1:0]  ram_q;

  // Derived values.
  logic [PROC_BITS-1:0] proc;
  logic                 pid_bad;
  logic [SIZE_W:0]      size_up;
  logic [NPG_W-1:0]     npg_calc;
  logic [BRK_W-1:0]     brk_cur;
  logic [SUM_W-1:0]     end_sum;
  logic                 alloc_ok;
  logic [PID_W-1:0]     owner_eff;
  logic                 owner_free;
  logic [FREE_W-1:0]    k_inc;
  logic [PAGE_BITS-1:0] frame_hit;
  logic                 walk_match;

  // Memory port controls.
  logic                 own_we;
  logic [PAGE_BITS-1:0] own_wa, own_ra;
  logic [PID_W-1:0]     own_wd;
  logic                 lnk_we;
  logic [PAGE_BITS-1:0] lnk_wa;
  logic [LINK_W-1:0]    lnk_wd;
  logic                 pm_we;
  logic [MAP_BITS-1:0]  pm_wa, pm_ra;
  logic [PAGE_BITS:0]   pm_wd;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_wa, ram_ra;
  logic [DATA_W-1:0]    ram_wd;

  assign proc     = PROC_BITS'(pid_r - PID_W'(1));
  assign pid_bad  = (pid_r == '0) || (pid_r > PID_W'(NUM_PROCS));
  assign size_up  = {1'b0, size_r} + (SIZE_W+1)'(PAGE_BYTES - 1);
  assign npg_calc = size_up[SIZE_W:OFFSET_BITS];
  assign brk_cur  = brk_r[proc];
  assign end_sum  = SUM_W'(brk_cur) + SUM_W'({npg_calc, {OFFSET_BITS{1'b0}}});
  assign alloc_ok = (size_r != '0) && (SUM_W'(free_cnt_r) >= SUM_W'(npg_calc))
                    && (end_sum <= SUM_W'(SPACE_BYTES));

  assign owner_eff  = owner_vq ? owner_q : '0;
  assign owner_free = (owner_eff == '0);
  assign k_inc      = k_r + FREE_W'(1);
  assign frame_hit  = pm_q[PAGE_BITS-1:0];
  assign walk_match = pm_q[PAGE_BITS] && (frame_hit == cur_r[PAGE_BITS-1:0]);

  always_comb begin
    sts               = '0;
    sts.clear_done    = (clr_r == '1);
    sts.in_fire       = in_ch.valid && ctl.in_ready;
    sts.pid_bad       = pid_bad;
    sts.is_alloc      = (cmd_r == CMD_ALLOC);
    sts.alloc_ok      = alloc_ok;
    sts.map_hit       = pm_q[PAGE_BITS];
    sts.is_read       = (cmd_r == CMD_READ);
    sts.is_write      = (cmd_r == CMD_WRITE);
    sts.scan_last     = (owner_free && (k_inc == npg_r)) || (i_r == '1);
    sts.walk_stop_rd  = steps_r[PAGE_BITS] || cur_r[PAGE_BITS];
    sts.walk_stop_chk = (owner_eff != pid_r);
    sts.out_free      = !out_valid_r || out_ch.ready;
  end

  assign in_ch.ready          = ctl.in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.alloc_address = out_addr_r;
  assign out_ch.read_data     = out_rdata_r;

  // Memory port selection.
  always_comb begin
    own_we = 1'b0;
    own_wa = i_r;
    own_wd = pid_r;
    own_ra = ctl.walk_rd ? cur_r[PAGE_BITS-1:0] : i_r;
    if (ctl.scan_chk && owner_free) begin
      own_we = 1'b1;
    end else if (ctl.walk_chk && !sts.walk_stop_chk) begin
      own_we = 1'b1;
      own_wa = cur_r[PAGE_BITS-1:0];
      own_wd = '0;
    end

    lnk_we = 1'b0;
    lnk_wa = prev_r[PAGE_BITS-1:0];
    lnk_wd = LINK_W'(i_r);
    if (ctl.scan_chk && owner_free && (prev_r != LINK_END)) begin
      lnk_we = 1'b1;
    end else if (ctl.scan_end && (prev_r != LINK_END)) begin
      lnk_we = 1'b1;
      lnk_wd = LINK_END;
    end

    pm_we = 1'b0;
    pm_wa = {proc, vp_r};
    pm_wd = {1'b1, i_r};
    pm_ra = ctl.dec ? {proc, addr_r[ADDRESS_BITS-1:OFFSET_BITS]} : {proc, vp_r};
    if (ctl.clear) begin
      pm_we = 1'b1;
      pm_wa = clr_r[MAP_BITS-1:0];
      pm_wd = '0;
    end else if (ctl.scan_chk && owner_free) begin
      pm_we = 1'b1;
    end else if (ctl.walk_chk && !sts.walk_stop_chk && walk_match) begin
      pm_we = 1'b1;
      pm_wd = '0;
    end

    ram_ra = {frame_hit, addr_r[OFFSET_BITS-1:0]};
    ram_wa = ram_ra;
    ram_wd = wdata_r;
    ram_we = 1'b0;
    if (ctl.clear) begin
      ram_we = 1'b1;
      ram_wa = clr_r[ADDRESS_BITS-1:0];
      ram_wd = '0;
    end else if (ctl.look_chk && pm_q[PAGE_BITS] && (cmd_r == CMD_WRITE)) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) owner_mem[own_wa] <= own_wd;
    owner_q <= owner_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) link_mem[lnk_wa] <= lnk_wd;
    link_q <= link_mem[cur_r[PAGE_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    pm_q <= pm_mem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_wa] <= ram_wd;
    ram_q <= ram_mem[ram_ra];
  end

  // Owner valid bits: a frame never written reads as free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < PAGE_COUNT; f++) owner_vld_r[f] <= 1'b0;
    end else if (own_we) begin
      owner_vld_r[own_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    owner_vq <= owner_vld_r[own_ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      free_cnt_r  <= FREE_W'(PAGE_COUNT);
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PROCS; p++) brk_r[p] <= BRK_W'(PAGE_BYTES);
    end else begin
      if (ctl.clear) clr_r <= clr_r + CLR_W'(1);
      if (ctl.dec && !pid_bad && (cmd_r == CMD_ALLOC) && alloc_ok) begin
        brk_r[proc] <= end_sum[BRK_W-1:0];
      end
      if (ctl.scan_chk && owner_free) begin
        free_cnt_r <= free_cnt_r - FREE_W'(1);
      end else if (ctl.walk_chk && !sts.walk_stop_chk) begin
        free_cnt_r <= free_cnt_r + FREE_W'(1);
      end
      if (ctl.publish) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sts.in_fire) begin
      cmd_r   <= cmd_t'(in_ch.command);
      pid_r   <= in_ch.pid;
      addr_r  <= in_ch.address;
      size_r  <= in_ch.alloc_size;
      wdata_r <= in_ch.write_data;
    end
    if (ctl.dec) begin
      res_status_r <= 1'b1;
      res_addr_r   <= '0;
      res_rdata_r  <= '0;
      npg_r        <= FREE_W'(npg_calc);
      k_r          <= '0;
      i_r          <= '0;
      prev_r       <= LINK_END;
      vp_r         <= brk_cur[ADDRESS_BITS-1:OFFSET_BITS];
      if (!pid_bad && (cmd_r == CMD_ALLOC) && alloc_ok) begin
        res_status_r <= 1'b0;
        res_addr_r   <= brk_cur[ADDR_W-1:0];
      end
    end
    if (ctl.look_chk && pm_q[PAGE_BITS]) begin
      if (cmd_r != CMD_READ) res_status_r <= 1'b0;
      cur_r   <= LINK_W'(frame_hit);
      vp_r    <= addr_r[ADDRESS_BITS-1:OFFSET_BITS];
      steps_r <= '0;
    end
    if (ctl.ram_done) begin
      res_status_r <= 1'b0;
      res_rdata_r  <= ram_q;
    end
    if (ctl.scan_chk) begin
      i_r <= i_r + PAGE_BITS'(1);
      if (owner_free) begin
        k_r    <= k_inc;
        prev_r <= LINK_W'(i_r);
        vp_r   <= vp_r + PAGE_BITS'(1);
      end
    end
    if (ctl.walk_chk) begin
      cur_r   <= link_q;
      vp_r    <= vp_r + PAGE_BITS'(1);
      steps_r <= steps_r + FREE_W'(1);
    end
    if (ctl.publish) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_rdata_r  <= res_rdata_r;
    end
  end

  a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FREE_W'(PAGE_COUNT))
    else $error("free frame count above frame total");

  a_publish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.publish |-> (!out_valid_r || out_ch.ready))
    else $error("result published over an untaken result");

  a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_end |-> (k_r == npg_r))
    else $error("allocation ended before all pages were mapped");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk_chk |-> !cur_r[PAGE_BITS])
    else $error("frame walk used a link outside the frame range");

endmodule

@@ rtl/paged_mmu_frame_allocator_unit.sv @@
// Paged memory unit with frame allocator, top level.
// Each item is decoded; a read then looks up the page map and reads the byte RAM, a
// write or unmapped access ends at the lookup, a bad pid or refused allocate ends at
// decode, a free walks its chain releasing its own frames and an allocate scans
// frames. One item in flight; a result waits in the output register while the next
// item is accepted. After reset a clearing pass zeroes the byte RAM and page map.
module paged_mmu_frame_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  pmfa_in_if.sink    in_ch,
  pmfa_out_if.source out_ch
);
  import pmfa_pkg::*;

  // Step commands from the state machine and status flags back from the datapath.
  ctl_t ctl;
  sts_t sts;

  // The controller sequences decode, page-map lookup, frame scan and chain walk.
  pmfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // The datapath holds all memories, counters and the result register.
  pmfa_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
